@@ rtl/sliding_window_median_defines.svh @@
// Assertion macros used by the checker of the sliding window median.
// Depends on nothing. Each macro expects clk and rst_n in the scope where it is used.
`ifndef SLIDING_WINDOW_MEDIAN_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define SWM_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define SWM_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

@@ rtl/swm_pkg.sv @@
// Shared constants and the result item layout of the sliding window median.
// Depends on nothing; used by the top level and by its checker.
package swm_pkg;

    // Widths of the item fields on the ports.
    localparam int SAMPLE_W    = 16;
    localparam int FILL_W      = 5;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 24;
    localparam int M_PAD_W     = M_TDATA_W - SAMPLE_W - FILL_W;

    // Result item as it sits in m_tdata, lowest field last.
    typedef struct packed {
        logic [M_PAD_W-1:0]  pad;
        logic [FILL_W-1:0]   fill_level;
        logic [SAMPLE_W-1:0] median_value;
    } out_item_t;

endpackage

@@ rtl/sliding_window_median.sv @@
// Running median filter over the last WINDOW samples, one channel.
// Depends on swm_pkg for the port widths and the result item layout.
//
// Usage:
// The slave channel (s_tvalid, s_tready, s_tdata) takes one signed sample
// per item. The master channel (m_tvalid, m_tready, m_tdata) returns one
// result item per sample: the upper median of the samples held and the
// number of samples it was taken over.
// Each accepted item starts a sweep over the sorted-value memory, which
// reads one entry and writes at most one entry per cycle through its one
// read port and its one write port; the sweep visits every sample held.
// The finished result then moves to the output register, and only after
// that is the next item accepted, so no new item is taken mid-sweep.
// A finished result waits in an output register, so a new item is taken
// while the receiver stalls; a second result waits until the first leaves.
// Reset empties the window and clears both channels; the sample memories
// need no clearing pass, since a value read from an entry not yet written is never used.
module sliding_window_median #(
    parameter int WINDOW      = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [swm_pkg::S_TDATA_W-1:0]  s_tdata,   // [15:0] sample
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [swm_pkg::M_TDATA_W-1:0]  m_tdata    // [15:0] median_value, [20:16] fill_level
);

    localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW = $clog2(WINDOW + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(WINDOW);
    localparam logic [IW-1:0] LAST_POS   = IW'(WINDOW - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // Samples in arrival order, and the same samples in ascending order.
    logic signed [SAMPLE_BITS-1:0] ring_mem [WINDOW];
    logic signed [SAMPLE_BITS-1:0] sort_mem [WINDOW];

    logic [1:0]                    state_reg, state_next;
    logic [IW-1:0]                 wp_reg, wp_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic [CW-1:0]                 p_reg, p_next;
    logic [CW-1:0]                 w_reg, w_next;
    logic                          ins_reg, ins_next;
    logic                          del_reg, del_next;
    logic                          hold_v_reg, hold_v_next;
    logic                          full_reg, full_next;
    logic                          out_valid_reg, out_valid_next;

    logic [CW-1:0]                 m_reg;
    logic [CW-1:0]                 k_reg;
    logic signed [SAMPLE_BITS-1:0] new_reg;
    logic signed [SAMPLE_BITS-1:0] old_reg;
    logic signed [SAMPLE_BITS-1:0] hold_reg;
    logic signed [SAMPLE_BITS-1:0] med_reg;
    logic signed [SAMPLE_BITS-1:0] sort_rd_reg;
    swm_pkg::out_item_t            out_data_reg;

    logic                                 in_acc;
    logic                                 out_load;
    logic [SAMPLE_BITS+swm_pkg::SAMPLE_W-1:0] in_ext;
    logic [SAMPLE_BITS+swm_pkg::SAMPLE_W-1:0] med_ext;
    logic [CW+swm_pkg::FILL_W-1:0]        fill_ext;
    logic signed [SAMPLE_BITS-1:0]        sample_in;
    logic [CW-1:0]                        p_inc;
    logic [IW-1:0]                        sort_raddr;
    logic                                 at_end;
    logic                                 hit_old;
    logic                                 emit_new;
    logic                                 emit_r;
    logic                                 sort_we;
    logic signed [SAMPLE_BITS-1:0]        sort_wdata;
    logic signed [SAMPLE_BITS-1:0]        hold_new;
    swm_pkg::out_item_t                   out_item;

    // Port side: the input is zero-extended or cut to the stored width.
    assign in_ext    = {{SAMPLE_BITS{1'b0}}, s_tdata};
    assign sample_in = in_ext[SAMPLE_BITS-1:0];
    assign in_acc    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // Merge step: the sorted list streams past once, the oldest sample drops
    // out once the window is full, and the new one drops in at its place.
    assign p_inc    = p_reg + CW'(1);
    assign at_end   = (p_reg == m_reg);
    assign hit_old  = full_reg && !del_reg && !at_end && (sort_rd_reg == old_reg);
    assign emit_new = !ins_reg && (at_end || (sort_rd_reg >= new_reg));
    assign emit_r   = !at_end && !hit_old;
    assign sort_raddr = ((state_reg == ST_RUN) && (p_inc < m_reg)) ? p_inc[IW-1:0] : '0;

    // At most one write per cycle; a value that cannot be written yet waits in hold.
    always_comb
    begin
        sort_we     = 1'b0;
        sort_wdata  = hold_reg;
        hold_v_next = hold_v_reg;
        hold_new    = hold_reg;
        if (state_reg == ST_RUN)
        begin
            if (hold_v_reg)
            begin
                sort_we     = 1'b1;
                sort_wdata  = hold_reg;
                hold_v_next = emit_r;
                hold_new    = sort_rd_reg;
            end
            else if (emit_new)
            begin
                sort_we     = 1'b1;
                sort_wdata  = new_reg;
                hold_v_next = emit_r;
                hold_new    = sort_rd_reg;
            end
            else if (emit_r)
            begin
                sort_we     = 1'b1;
                sort_wdata  = sort_rd_reg;
                hold_v_next = 1'b0;
            end
            else
            begin
                hold_v_next = 1'b0;
            end
        end
        else if (in_acc)
        begin
            hold_v_next = 1'b0;
        end
    end

    // Sequencer for one item: accept, sweep, hand over the result.
    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        cnt_next       = cnt_reg;
        p_next         = p_reg;
        w_next         = w_reg;
        ins_next       = ins_reg;
        del_next       = del_reg;
        full_next      = full_reg;
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_RUN;
                    wp_next    = (wp_reg == LAST_POS) ? '0 : wp_reg + IW'(1);
                    cnt_next   = (cnt_reg == FULL_COUNT) ? cnt_reg : cnt_reg + CW'(1);
                    full_next  = (cnt_reg == FULL_COUNT);
                    p_next     = '0;
                    w_next     = '0;
                    ins_next   = 1'b0;
                    del_next   = 1'b0;
                end
            end
            ST_RUN:
            begin
                p_next   = p_inc;
                w_next   = sort_we ? w_reg + CW'(1) : w_reg;
                ins_next = ins_reg || emit_new;
                del_next = del_reg || hit_old;
                if (at_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            cnt_reg       <= '0;
            p_reg         <= '0;
            w_reg         <= '0;
            ins_reg       <= 1'b0;
            del_reg       <= 1'b0;
            hold_v_reg    <= 1'b0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            cnt_reg       <= cnt_next;
            p_reg         <= p_next;
            w_reg         <= w_next;
            ins_reg       <= ins_next;
            del_reg       <= del_next;
            hold_v_reg    <= hold_v_next;
            full_reg      <= full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Arrival-order memory: the oldest sample is read as the new one replaces it.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            old_reg          <= ring_mem[wp_reg];
            ring_mem[wp_reg] <= sample_in;
        end
    end

    // Sorted memory: reads run at least one entry ahead of the writes.
    always_ff @(posedge clk)
    begin
        if (sort_we)
        begin
            sort_mem[w_reg[IW-1:0]] <= sort_wdata;
        end
        sort_rd_reg <= sort_mem[sort_raddr];
    end

    // Item payload and the median picked off the write stream.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            new_reg <= sample_in;
            m_reg   <= cnt_reg;
            k_reg   <= cnt_next >> 1;
        end
        hold_reg <= hold_new;
        if (sort_we && (w_reg == k_reg))
        begin
            med_reg <= sort_wdata;
        end
        if (out_load)
        begin
            out_data_reg <= out_item;
        end
    end

    // Result item packing.
    assign med_ext  = {{swm_pkg::SAMPLE_W{1'b0}}, med_reg};
    assign fill_ext = {{swm_pkg::FILL_W{1'b0}}, cnt_reg};

    always_comb
    begin
        out_item              = '0;
        out_item.median_value = med_ext[swm_pkg::SAMPLE_W-1:0];
        out_item.fill_level   = fill_ext[swm_pkg::FILL_W-1:0];
    end

endmodule

@@ rtl/swm_checker.sv @@
// Port-level checks for the sliding window median, bound to the top level.
// Depends on swm_pkg and on the macros in sliding_window_median_defines.svh.
`include "sliding_window_median_defines.svh"

module swm_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [swm_pkg::M_TDATA_W-1:0] m_tdata
);

    logic [1:0] pending_reg;
    logic [1:0] pending_next;

    // Items accepted whose result has not yet been taken.
    always_comb
    begin
        pending_next = pending_reg;
        if ((s_tvalid && s_tready) && !(m_tvalid && m_tready))
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (!(s_tvalid && s_tready) && (m_tvalid && m_tready))
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `SWM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `SWM_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "stalled result changed")
    `SWM_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "item taken while busy")
    `SWM_ASSERT_NOW(a_no_spurious_result, m_tvalid, pending_reg != 2'd0, "result without an item")

endmodule

bind sliding_window_median swm_checker u_swm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
